@@ hw/rtl/nfa_pkg.sv @@
// Package with shared request codes, register indexes, field widths and controller states of the NFA matcher.
`timescale 1ns / 1ps

package nfa_pkg;

    // Request type codes carried on req_type.
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_SYM   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_START_STATE = 1'b0;
    localparam logic CFG_TERM_MASK   = 1'b1;

    // Field and register widths fixed by the interface.
    localparam int FIELD_W = 5;
    localparam int CFG_W   = 32;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_SYM,
        S_FLUSH
    } ctrl_state_t;

endpackage

@@ hw/rtl/nfa_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module nfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write when enabled; read data is registered and appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hw/rtl/nfa_state_set_matcher_top.sv @@
// Top level of the NFA state-set matcher: controller, active set and transition store.
`timescale 1ns / 1ps
// Timing: a start request gives its result in the cycle after acceptance; an add request
// reads its row, then writes it merged in S_ADD; a symbol request reads one row per state.
// Throughput: one request at a time, set by the single store port reading one row a cycle.
// Reset: configuration and active set clear at once; a clearing pass then writes zero to
// all 2**(state bits + symbol bits) store rows (1024 at the defaults) before requests.

module nfa_state_set_matcher_top #(
    parameter int NUM_STATES  = 32,
    parameter int NUM_SYMBOLS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Request channel.
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic [nfa_pkg::FIELD_W-1:0] symbol,
    input  logic [nfa_pkg::FIELD_W-1:0] from_state,
    input  logic [nfa_pkg::FIELD_W-1:0] to_state,
    // Result channel.
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        accepted,
    output logic                        alive,
    // Configuration write port.
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [nfa_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int ST_W   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int SYM_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int ADDR_W = ST_W + SYM_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // Control registers.
    nfa_pkg::ctrl_state_t state_reg, state_next;
    logic [ST_W:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NUM_STATES-1:0] active_reg, active_next;
    logic [nfa_pkg::FIELD_W-1:0] start_state_reg;
    logic [nfa_pkg::CFG_W-1:0]   term_mask_reg;

    // Payload registers.
    logic [NUM_STATES-1:0] acc_reg, acc_next;
    logic [NUM_STATES-1:0] bit_reg, bit_next;
    logic                  add_ok_reg, add_ok_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic [ST_W-1:0]       vpipe_reg, vpipe_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic                  accepted_reg, accepted_next;
    logic                  alive_reg, alive_next;

    // Store port.
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [NUM_STATES-1:0] mem_wdata;
    logic [NUM_STATES-1:0] mem_rdata;

    // Decoded request fields.
    logic                  in_fire;
    logic [ST_W-1:0]       from_idx;
    logic [ST_W-1:0]       to_idx;
    logic [SYM_W-1:0]      sym_idx;
    logic                  from_ok;
    logic                  to_ok;
    logic                  sym_ok;
    logic                  start_ok;
    logic [NUM_STATES-1:0] term_vec;

    nfa_ram #(
        .WIDTH (NUM_STATES),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == nfa_pkg::S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign alive     = alive_reg;

    // Range checks and index narrowing; the checks guard each narrowed index.
    assign from_ok  = 32'(from_state) < NUM_STATES;
    assign to_ok    = 32'(to_state) < NUM_STATES;
    assign sym_ok   = 32'(symbol) < NUM_SYMBOLS;
    assign start_ok = 32'(start_state_reg) < NUM_STATES;
    assign from_idx = ST_W'(from_state);
    assign to_idx   = ST_W'(to_state);
    assign sym_idx  = SYM_W'(symbol);
    assign term_vec = NUM_STATES'(term_mask_reg);

    // Next state, store access and datapath.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        active_next    = active_reg;
        acc_next       = acc_reg;
        bit_next       = bit_reg;
        add_ok_next    = add_ok_reg;
        sym_next       = sym_reg;
        vpipe_next     = vpipe_reg;
        addr_next      = addr_reg;
        accepted_next  = accepted_reg;
        alive_next     = alive_reg;
        mem_we         = 1'b0;
        mem_addr       = addr_reg;
        mem_wdata      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            nfa_pkg::S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = nfa_pkg::S_IDLE;
                end
            end

            nfa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    case (req_type)
                        nfa_pkg::REQ_ADD:
                        begin
                            // Read the row now, merge the target bit next cycle.
                            mem_addr    = {from_idx, sym_idx};
                            addr_next   = {from_idx, sym_idx};
                            bit_next    = NUM_STATES'(1) << to_idx;
                            add_ok_next = from_ok && to_ok && sym_ok;
                            state_next  = nfa_pkg::S_ADD;
                        end
                        nfa_pkg::REQ_START:
                        begin
                            active_next    = start_ok ?
                                             (NUM_STATES'(1) << ST_W'(start_state_reg)) : '0;
                            accepted_next  = |(active_next & term_vec);
                            alive_next     = |active_next;
                            out_valid_next = 1'b1;
                        end
                        nfa_pkg::REQ_SYM:
                        begin
                            if (sym_ok)
                            begin
                                // Issue the read for state 0 and walk the rest.
                                mem_addr   = {ST_W'(0), sym_idx};
                                sym_next   = sym_idx;
                                vpipe_next = '0;
                                cnt_next   = (ST_W + 1)'(1);
                                acc_next   = '0;
                                state_next = nfa_pkg::S_SYM;
                            end
                            else
                            begin
                                // No row exists for this symbol: the set empties.
                                active_next    = '0;
                                accepted_next  = 1'b0;
                                alive_next     = 1'b0;
                                out_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Unused request code is dropped.
                        end
                    endcase
                end
            end

            nfa_pkg::S_ADD:
            begin
                mem_addr   = addr_reg;
                mem_wdata  = mem_rdata | bit_reg;
                mem_we     = add_ok_reg;
                state_next = nfa_pkg::S_IDLE;
            end

            nfa_pkg::S_SYM:
            begin
                // Fold in the row of the state read last cycle if it is active.
                if (active_reg[vpipe_reg])
                begin
                    acc_next = acc_reg | mem_rdata;
                end
                if (32'(cnt_reg) < NUM_STATES)
                begin
                    mem_addr   = {cnt_reg[ST_W-1:0], sym_reg};
                    vpipe_next = cnt_reg[ST_W-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = nfa_pkg::S_FLUSH;
                end
            end

            nfa_pkg::S_FLUSH:
            begin
                // Hold the new set until the result register is free.
                if (!out_valid_reg || out_ready)
                begin
                    active_next    = acc_reg;
                    accepted_next  = |(acc_reg & term_vec);
                    alive_next     = |acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = nfa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = nfa_pkg::S_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= nfa_pkg::S_CLEAR;
            cnt_reg         <= '0;
            clr_addr_reg    <= '0;
            out_valid_reg   <= 1'b0;
            active_reg      <= '0;
            start_state_reg <= '0;
            term_mask_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    nfa_pkg::CFG_START_STATE:
                        start_state_reg <= cfg_wdata[nfa_pkg::FIELD_W-1:0];
                    nfa_pkg::CFG_TERM_MASK:
                        term_mask_reg   <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        bit_reg      <= bit_next;
        add_ok_reg   <= add_ok_next;
        sym_reg      <= sym_next;
        vpipe_reg    <= vpipe_next;
        addr_reg     <= addr_next;
        accepted_reg <= accepted_next;
        alive_reg    <= alive_next;
    end

endmodule

@@ bench/nfa_state_set_matcher_top_tb.sv @@
// Self-checking testbench for the NFA state-set matcher with a built-in automaton predictor.
`timescale 1ns / 1ps

module nfa_state_set_matcher_top_tb;

    localparam int N_ST  = 32;
    localparam int N_SYM = 32;

    // Request code that the block must ignore.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // The slowest request is a symbol request, which reads one store row per state.
    localparam int SETTLE_CYCLES = N_ST + 8;
    // Cycles with no handshake before the run is declared hung.
    localparam int HANG_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [nfa_pkg::FIELD_W-1:0] sym;
        logic [nfa_pkg::FIELD_W-1:0] src;
        logic [nfa_pkg::FIELD_W-1:0] dst;
    } nfa_request_t;

    typedef struct packed {
        logic acc;
        logic live;
    } nfa_verdict_t;

    // Block ports.
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [1:0]                  req_type = nfa_pkg::REQ_ADD;
    logic [nfa_pkg::FIELD_W-1:0] symbol = '0;
    logic [nfa_pkg::FIELD_W-1:0] from_state = '0;
    logic [nfa_pkg::FIELD_W-1:0] to_state = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b1;
    logic                        accepted;
    logic                        alive;
    logic                        cfg_we = 1'b0;
    logic                        cfg_index = nfa_pkg::CFG_START_STATE;
    logic [nfa_pkg::CFG_W-1:0]   cfg_wdata = '0;

    // Predicted automaton: configuration, active set and transition rows.
    logic [nfa_pkg::FIELD_W-1:0] start_cfg = '0;
    logic [N_ST-1:0]    accept_mask = '0;
    logic [N_ST-1:0]    live_set = '0;
    logic [N_ST-1:0]    row_store [N_ST][N_SYM];

    // Requests waiting to be sent and verdicts waiting to come back.
    nfa_request_t       request_q[$];
    nfa_verdict_t       verdict_q[$];
    int                 unsent_count = 0;
    nfa_request_t       cur_req;

    // Handshake pacing.
    logic               quiet_in = 1'b0;
    logic               quiet_out = 1'b0;
    int unsigned        idle_left = 0;
    int unsigned        gap_now;
    int unsigned        stall_left = 0;
    int unsigned        stall_draw;
    nfa_verdict_t       want;

    int unsigned        error_count = 0;
    int unsigned        hang_cycles = 0;

    nfa_state_set_matcher_top #(
        .NUM_STATES  (N_ST),
        .NUM_SYMBOLS (N_SYM)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .symbol     (symbol),
        .from_state (from_state),
        .to_state   (to_state),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .accepted   (accepted),
        .alive      (alive),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Prints one mismatch line and counts it.
    task automatic log_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned draw_gap(input logic quiet);
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // Draws any 5-bit field value.
    function automatic logic [4:0] rand_field();
        return 5'($urandom_range(0, 31));
    endfunction

    // Applies one accepted request to the predicted automaton.
    task automatic advance_automaton(input nfa_request_t r);
        logic [N_ST-1:0] next_set;
        logic            gives_result;
        nfa_verdict_t    v;
        next_set = '0;
        gives_result = 1'b0;
        case (r.kind)
            nfa_pkg::REQ_ADD:
            begin
                if (r.src < N_ST && r.dst < N_ST && r.sym < N_SYM)
                    row_store[r.src][r.sym][r.dst] = 1'b1;
            end
            nfa_pkg::REQ_START:
            begin
                live_set = '0;
                if (start_cfg < N_ST)
                    live_set[start_cfg] = 1'b1;
                gives_result = 1'b1;
            end
            nfa_pkg::REQ_SYM:
            begin
                if (r.sym < N_SYM)
                begin
                    for (int s = 0; s < N_ST; s++)
                        if (live_set[s])
                            next_set |= row_store[s][r.sym];
                end
                live_set = next_set;
                gives_result = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (gives_result)
        begin
            v.acc  = |(live_set & accept_mask);
            v.live = |live_set;
            verdict_q = {verdict_q, v};
        end
    endtask

    task automatic queue_request(input logic [1:0] kind, input logic [4:0] sym,
                                 input logic [4:0] src, input logic [4:0] dst);
        nfa_request_t r;
        r.kind = kind;
        r.sym  = sym;
        r.src  = src;
        r.dst  = dst;
        request_q = {request_q, r};
        unsent_count++;
    endtask

    // Writes both registers back to back; the block is idle whenever this runs.
    task automatic write_config(input logic [4:0] st, input logic [31:0] mask);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= nfa_pkg::CFG_START_STATE;
        cfg_wdata <= {{(nfa_pkg::CFG_W-nfa_pkg::FIELD_W){1'b0}}, st};
        @(posedge clk);
        cfg_index <= nfa_pkg::CFG_TERM_MASK;
        cfg_wdata <= mask;
        @(posedge clk);
        cfg_we    <= 1'b0;
        start_cfg   = st;
        accept_mask = mask;
    endtask

    // Waits until every request is sent and every verdict is back, then lets the block settle.
    task automatic drain_and_settle;
        do
            @(negedge clk);
        while (unsent_count != 0 || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Builds a small automaton over a few states and symbols and runs words through it,
    // mixed with unconstrained noise requests.
    task automatic queue_random_phase(input int budget);
        logic [4:0] alpha [4];
        logic [4:0] pool [6];
        int         n_sym;
        int         n_pool;
        int         made;
        int         pick;
        int         len;
        logic [1:0] kind;
        logic [4:0] sym;
        logic [4:0] dst;
        n_sym  = $urandom_range(1, 4);
        n_pool = $urandom_range(2, 6);
        for (int i = 0; i < 4; i++)
            alpha[i] = rand_field();
        for (int i = 0; i < 6; i++)
            pool[i] = rand_field();
        pool[0] = start_cfg;
        made = 0;
        while (made < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // Transition inside the pool, now and then to a state outside it.
                dst = ($urandom_range(0, 9) == 0) ? rand_field()
                                                  : pool[$urandom_range(0, n_pool - 1)];
                queue_request(nfa_pkg::REQ_ADD, alpha[$urandom_range(0, n_sym - 1)],
                              pool[$urandom_range(0, n_pool - 1)], dst);
                made++;
            end
            else if (pick < 88)
            begin
                // A word: start, then a run of symbols mostly from the alphabet.
                len = $urandom_range(0, 10);
                queue_request(nfa_pkg::REQ_START, rand_field(), rand_field(), rand_field());
                made++;
                for (int k = 0; k < len; k++)
                begin
                    sym = ($urandom_range(0, 9) == 0) ? rand_field()
                                                      : alpha[$urandom_range(0, n_sym - 1)];
                    queue_request(nfa_pkg::REQ_SYM, sym, rand_field(), rand_field());
                    made++;
                end
            end
            else
            begin
                // Noise: any request code with arbitrary fields.
                kind = 2'($urandom_range(0, 3));
                queue_request(kind, rand_field(), rand_field(), rand_field());
                if (kind != REQ_UNUSED)
                    made++;
            end
        end
    endtask

    // Request driver: presents queued requests after a random idle gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                advance_automaton(cur_req);
                unsent_count--;
            end
            if (!(in_valid && !in_ready))
            begin
                gap_now = in_valid ? draw_gap(quiet_in) : idle_left;
                if (gap_now == 0 && request_q.size() != 0)
                begin
                    cur_req = request_q.pop_front();
                    in_valid   <= 1'b1;
                    req_type   <= cur_req.kind;
                    symbol     <= cur_req.sym;
                    from_state <= cur_req.src;
                    to_state   <= cur_req.dst;
                    idle_left  <= 0;
                end
                else
                begin
                    in_valid  <= 1'b0;
                    idle_left <= (gap_now == 0) ? 0 : gap_now - 1;
                end
            end
        end
    end

    // Result monitor: compares each result with the oldest verdict and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    log_mismatch("result arrived with no request waiting for one");
                else
                begin
                    want = verdict_q.pop_front();
                    if (accepted !== want.acc)
                        log_mismatch($sformatf("accepted is %b, predicted %b",
                                               accepted, want.acc));
                    if (alive !== want.live)
                        log_mismatch($sformatf("alive is %b, predicted %b", alive, want.live));
                end
                stall_draw = draw_gap(quiet_out);
                stall_left <= stall_draw;
                out_ready  <= (stall_draw == 0);
            end
            else if (out_valid && stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= (stall_left == 1);
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT)
        begin
            $display("nfa_state_set_matcher_top: mismatch");
            $finish;
        end
    end

    // Main sequence: reset, directed requests, then randomized phases under new settings.
    initial
    begin
        for (int s = 0; s < N_ST; s++)
            for (int y = 0; y < N_SYM; y++)
                row_store[s][y] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The store clearing pass holds off requests; wait for it before the first write.
        do
            @(negedge clk);
        while (!in_ready);

        // Directed part: empty store, extreme states and symbols, ignored code.
        write_config(5'd0, 32'h8000_0001);
        queue_request(nfa_pkg::REQ_START, 5'd31, 5'd31, 5'd31);
        queue_request(nfa_pkg::REQ_SYM, 5'd0, 5'd0, 5'd0);
        queue_request(REQ_UNUSED, 5'd31, 5'd31, 5'd31);
        queue_request(nfa_pkg::REQ_ADD, 5'd0, 5'd0, 5'd31);
        queue_request(nfa_pkg::REQ_ADD, 5'd31, 5'd31, 5'd0);
        queue_request(nfa_pkg::REQ_ADD, 5'd31, 5'd31, 5'd31);
        queue_request(nfa_pkg::REQ_ADD, 5'd0, 5'd0, 5'd1);
        queue_request(nfa_pkg::REQ_START, 5'd0, 5'd0, 5'd0);
        queue_request(nfa_pkg::REQ_SYM, 5'd0, 5'd31, 5'd31);
        queue_request(nfa_pkg::REQ_SYM, 5'd31, 5'd0, 5'd0);
        queue_request(nfa_pkg::REQ_SYM, 5'd5, 5'd0, 5'd0);
        queue_request(nfa_pkg::REQ_SYM, 5'd0, 5'd0, 5'd0);
        queue_request(nfa_pkg::REQ_START, 5'd0, 5'd0, 5'd0);
        queue_request(REQ_UNUSED, 5'd0, 5'd0, 5'd0);
        queue_request(nfa_pkg::REQ_SYM, 5'd0, 5'd0, 5'd0);
        queue_request(nfa_pkg::REQ_ADD, 5'd0, 5'd0, 5'd31);
        queue_request(nfa_pkg::REQ_SYM, 5'd31, 5'd0, 5'd0);
        queue_request(nfa_pkg::REQ_ADD, 5'd31, 5'd1, 5'd31);
        queue_request(nfa_pkg::REQ_SYM, 5'd31, 5'd0, 5'd0);
        drain_and_settle();

        // Randomized phases, each under its own register settings, with pacing set per phase.
        for (int ph = 1; ph <= 7; ph++)
        begin
            quiet_in  = (ph == 2 || ph == 5);
            quiet_out = (ph == 2 || ph == 6);
            case (ph)
                1: write_config(5'd31, 32'hFFFF_FFFF);
                2: write_config(5'd0, 32'h0000_0000);
                4: write_config(5'd31, 32'h0000_0001);
                default: write_config(rand_field(), 32'($urandom()));
            endcase
            // First add the start state to the row of state 31 on symbol 31, so words can reach it.
            queue_request(nfa_pkg::REQ_ADD, 5'd31, 5'd31, start_cfg);
            queue_random_phase(205);
            drain_and_settle();
        end

        if (error_count == 0)
            $display("nfa_state_set_matcher_top: match");
        else
            $display("nfa_state_set_matcher_top: mismatch");
        $finish;
    end

endmodule
